>>> hw/rtl/kber_pkg.sv
// Package for the keyboard bitmap edge and auto-repeat block.
// Holds the transaction payload structs, sequencer states, fixed constants and the usable-bit mask function.
// No dependencies.
package kber_pkg;

  // One input transaction: a bitmap slice or a failed poll
  typedef struct packed {
    logic        mode;
    logic [1:0]  word_index;
    logic [63:0] key_bits;
    logic        last_word;
    logic        shift_held;
    logic        control_held;
    logic        caps_lock_on;
    logic [63:0] now_us;
  } kber_in_t;

  // One result transaction: a key event or a status-only word
  typedef struct packed {
    logic       key_valid;
    logic [7:0] key_usage;
    logic       out_shift;
    logic       out_control;
    logic       out_caps;
    logic       is_repeat;
    logic       keyboard_present;
    logic       last_of_run;
  } kber_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PREP,
    ST_SCAN,
    ST_CHK_RD,
    ST_CHK,
    ST_FLUSH
  } kber_state_t;

  localparam int          CFG_W       = 24;
  localparam logic [7:0]  MOD_BASE    = 8'hE0;
  localparam logic [6:0]  MAX_RESULTS = 7'd64;
  localparam logic [23:0] DELAY_RST   = 24'd400000;
  localparam logic [23:0] PERIOD_RST  = 24'd35000;

  // Register indexes
  localparam logic REG_DELAY  = 1'b0;
  localparam logic REG_PERIOD = 1'b1;

  // Bits of a slice whose usages sit below the modifier range
  function automatic logic [63:0] usable_mask(input logic [1:0] w);
    logic [63:0] m;
    if (w < MOD_BASE[7:6]) begin
      m = '1;
    end else if (w == MOD_BASE[7:6]) begin
      m = (64'd1 << MOD_BASE[5:0]) - 64'd1;
    end else begin
      m = '0;
    end
    return m;
  endfunction

endpackage

>>> hw/rtl/kber_time.sv
// Shared time unit: one 64-bit add for rescheduling and one deadline compare.
// Depends on kber_pkg for the register width.
module kber_time (
  input  logic [63:0]              now,
  input  logic [kber_pkg::CFG_W-1:0] addend,
  input  logic [63:0]              deadline,
  output logic [63:0]              sum,
  output logic                     due
);
  import kber_pkg::*;

  // Time sums wrap modulo 2^64
  assign sum = now + {{(64 - CFG_W){1'b0}}, addend};

  // Unsigned deadline test
  assign due = (now >= deadline);

endmodule

>>> hw/rtl/keyboard_bitmap_edge_and_repeat_top.sv
// Keyboard bitmap edge detector with typematic auto-repeat, top level.
// Depends on kber_pkg and kber_time.
//
//   channel | ports                              | direction
//   input   | in_valid, in_stall, in_data        | slice or failed-poll transaction in
//   result  | out_valid, out_stall, out_data     | key or status transaction out
//   config  | cfg_we, cfg_index, cfg_wdata       | delay and period registers
//
// Accept to next accept: a failed poll passes flush and idle. A slice passes load, prepare,
// a scan of the 64 bits (one bitmap bit per cycle through the shared time adder unless a key
// waits), a repeat check read, a flush and idle; a last slice with a live repeat key adds a
// compare state. A key that finds the hold stage full under out_stall waits, as does the flush.
// rst_n is synchronous; it clears the stored bitmap valid bits, repeat state and presence
// flag and loads the register defaults. One result waits in a hold stage so the last one
// of a run can be flagged; the block is busy (in_stall high) outside idle.
module keyboard_bitmap_edge_and_repeat_top #(
  parameter int KEY_WORDS = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  kber_pkg::kber_in_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output kber_pkg::kber_out_t        out_data,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [kber_pkg::CFG_W-1:0] cfg_wdata
);
  import kber_pkg::*;

  localparam int         AW  = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam logic [2:0] KW3 = 3'(KEY_WORDS);

  kber_state_t state_r, state_nxt;

  logic [CFG_W-1:0] delay_r, period_r;
  kber_in_t         in_r, in_nxt;
  logic [63:0]      fresh_r, fresh_nxt;
  logic [5:0]       bit_r, bit_nxt;
  logic [6:0]       count_r, count_nxt;
  logic [7:0]       rkey_r, rkey_nxt;
  logic             rheld_r, rheld_nxt;
  logic [63:0]      deadline_r, deadline_nxt;
  logic             present_r, present_nxt;
  kber_out_t        hold_r, hold_nxt;
  logic             hold_vld_r, hold_vld_nxt;
  logic             out_valid_r;
  kber_out_t        out_data_r;

  // Stored previous bitmap slices
  logic [63:0]          prev_mem [0:KEY_WORDS-1];
  logic [KEY_WORDS-1:0] prev_vld_r;
  logic [63:0]          rd_r;
  logic [1:0]           rd_addr;
  logic                 rd_en, rd_ok, mem_we;
  logic [AW-1:0]        rd_idx, wr_idx;

  logic             out_free, push;
  kber_out_t        push_data, fresh_res, rep_res;
  logic [CFG_W-1:0] addend;
  logic [63:0]      sum;
  logic             due, w_ok, kw_ok;

  kber_time u_time (
    .now      (in_r.now_us),
    .addend   (addend),
    .deadline (deadline_r),
    .sum      (sum),
    .due      (due)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign w_ok   = ({1'b0, in_r.word_index} < KW3);
  assign kw_ok  = ({1'b0, rkey_r[7:6]} < KW3);
  assign addend = (state_r == ST_CHK) ? period_r : delay_r;

  // Single read port: slice on load, repeat key's slice on check
  assign rd_addr = (state_r == ST_CHK_RD) ? rkey_r[7:6] : in_r.word_index;
  assign rd_en   = (state_r == ST_LOAD) || (state_r == ST_CHK_RD);
  assign rd_ok   = ({1'b0, rd_addr} < KW3);
  assign rd_idx  = rd_addr[AW-1:0];
  assign wr_idx  = in_r.word_index[AW-1:0];
  assign mem_we  = (state_r == ST_LOAD) && w_ok;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      prev_mem[wr_idx] <= in_r.key_bits;
    end
    if (rd_en) begin
      rd_r <= (rd_ok && prev_vld_r[rd_idx]) ? prev_mem[rd_idx] : '0;
    end
  end

  // Result words built from the current transaction
  always_comb begin
    fresh_res                  = '0;
    fresh_res.key_valid        = 1'b1;
    fresh_res.key_usage        = {in_r.word_index, bit_r};
    fresh_res.out_shift        = in_r.shift_held;
    fresh_res.out_control      = in_r.control_held;
    fresh_res.out_caps         = in_r.caps_lock_on;
    fresh_res.keyboard_present = 1'b1;

    rep_res                  = '0;
    rep_res.key_valid        = 1'b1;
    rep_res.key_usage        = rkey_r;
    rep_res.out_shift        = in_r.shift_held;
    rep_res.out_control      = in_r.control_held;
    rep_res.out_caps         = in_r.caps_lock_on;
    rep_res.is_repeat        = 1'b1;
    rep_res.keyboard_present = present_r;
  end

  // Sequencer: next state and datapath controls
  always_comb begin
    state_nxt    = state_r;
    in_nxt       = in_r;
    fresh_nxt    = fresh_r;
    bit_nxt      = bit_r;
    count_nxt    = count_r;
    rkey_nxt     = rkey_r;
    rheld_nxt    = rheld_r;
    deadline_nxt = deadline_r;
    present_nxt  = present_r;
    hold_nxt     = hold_r;
    hold_vld_nxt = hold_vld_r;
    push         = 1'b0;
    push_data    = hold_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_data;
          count_nxt = '0;
          if (in_data.mode) begin
            present_nxt = 1'b0;
            state_nxt   = ST_FLUSH;
          end else begin
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        fresh_nxt = w_ok ? (in_r.key_bits & ~rd_r & usable_mask(in_r.word_index)) : '0;
        bit_nxt   = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (!(fresh_r[0] && hold_vld_r && !out_free)) begin
          if (fresh_r[0]) begin
            // Older held result is not the last one
            if (hold_vld_r) begin
              push                  = 1'b1;
              push_data             = hold_r;
              push_data.last_of_run = 1'b0;
            end
            hold_nxt     = fresh_res;
            hold_vld_nxt = 1'b1;
            present_nxt  = 1'b1;
            rkey_nxt     = fresh_res.key_usage;
            rheld_nxt    = (fresh_res.key_usage != 8'd0);
            deadline_nxt = sum;
            count_nxt    = 7'(count_r + 7'd1);
          end
          fresh_nxt = fresh_r >> 1;
          bit_nxt   = bit_r + 6'd1;
          if (bit_r == 6'd63) begin
            state_nxt = ST_CHK_RD;
          end
        end
      end
      ST_CHK_RD: begin
        if (in_r.last_word && rheld_r) begin
          if (kw_ok) begin
            state_nxt = ST_CHK;
          end else begin
            rheld_nxt = 1'b0;
            rkey_nxt  = '0;
            state_nxt = ST_FLUSH;
          end
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_CHK: begin
        if (!rd_r[rkey_r[5:0]]) begin
          // Repeat key released
          rheld_nxt = 1'b0;
          rkey_nxt  = '0;
          state_nxt = ST_FLUSH;
        end else if (due && (count_r < MAX_RESULTS)) begin
          if (!(hold_vld_r && !out_free)) begin
            if (hold_vld_r) begin
              push                  = 1'b1;
              push_data             = hold_r;
              push_data.last_of_run = 1'b0;
            end
            hold_nxt     = rep_res;
            hold_vld_nxt = 1'b1;
            deadline_nxt = sum;
            state_nxt    = ST_FLUSH;
          end
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          push = 1'b1;
          if (hold_vld_r) begin
            push_data = hold_r;
          end else begin
            push_data                  = '0;
            push_data.keyboard_present = present_r;
          end
          push_data.last_of_run = 1'b1;
          hold_vld_nxt          = 1'b0;
          state_nxt             = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rkey_r      <= '0;
      rheld_r     <= 1'b0;
      deadline_r  <= '0;
      present_r   <= 1'b0;
      hold_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prev_vld_r  <= '0;
      delay_r     <= DELAY_RST;
      period_r    <= PERIOD_RST;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      rkey_r     <= rkey_nxt;
      rheld_r    <= rheld_nxt;
      deadline_r <= deadline_nxt;
      present_r  <= present_nxt;
      hold_vld_r <= hold_vld_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (mem_we) begin
        prev_vld_r[wr_idx] <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_DELAY:  delay_r  <= cfg_wdata;
          REG_PERIOD: period_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    in_r    <= in_nxt;
    fresh_r <= fresh_nxt;
    bit_r   <= bit_nxt;
    hold_r  <= hold_nxt;
    if (push) begin
      out_data_r <= push_data;
    end
  end

  // Checks
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_RESULTS)
    else $error("fresh key count past result limit");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.key_valid |-> out_data.last_of_run && out_data.key_usage == 8'd0)
    else $error("status result not alone or carries a usage");

  a_repeat_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_repeat |-> out_data.last_of_run)
    else $error("repeat result not last of its run");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again without processing");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !hold_vld_r)
    else $error("held result left behind in idle");

endmodule
